// ----- sv/jhse_pkg.sv -----
// ----------------------------------------------------------------------------
// JPEG header segment extractor - shared package
// Word types, status codes and parse phase encoding.
// ----------------------------------------------------------------------------
package jhse_pkg;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_SOS    = 8'hDA;

  localparam logic [2:0] ST_IN_HEADER  = 3'd0;
  localparam logic [2:0] ST_COMPLETE   = 3'd1;
  localparam logic [2:0] ST_PAST       = 3'd2;
  localparam logic [2:0] ST_NO_SOI     = 3'd3;
  localparam logic [2:0] ST_BAD_PREFIX = 3'd4;
  localparam logic [2:0] ST_EOI_EARLY  = 3'd5;
  localparam logic [2:0] ST_BAD_LEN    = 3'd6;
  localparam logic [2:0] ST_TRUNCATED  = 3'd7;

  typedef enum logic [7:0] {
    PH_SOI0     = 8'b0000_0001,
    PH_SOI1     = 8'b0000_0010,
    PH_PREFIX   = 8'b0000_0100,
    PH_CODE     = 8'b0000_1000,
    PH_LENH     = 8'b0001_0000,
    PH_LENL     = 8'b0010_0000,
    PH_PAYLOAD  = 8'b0100_0000,
    PH_FINISHED = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } item_t;

  typedef struct packed {
    logic       keep;
    logic [7:0] byte_out;
    logic [2:0] status;
    logic       last;
  } res_t;

endpackage

// ----- sv/jhse_in_if.sv -----
// ----------------------------------------------------------------------------
// JPEG header segment extractor - input channel
// Valid/ready channel carrying one file byte or an end-of-stream word.
// ----------------------------------------------------------------------------
interface jhse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

// ----- sv/jhse_out_if.sv -----
// ----------------------------------------------------------------------------
// JPEG header segment extractor - result channel
// Valid/ready channel carrying one classified byte per word.
// ----------------------------------------------------------------------------
interface jhse_out_if;
  logic       valid;
  logic       ready;
  logic       keep;
  logic [7:0] byte_out;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output keep, output byte_out, output status,
                  output last, input ready);
  modport sink   (input valid, input keep, input byte_out, input status,
                  input last, output ready);
endinterface

// ----- sv/jhse_parse.sv -----
// ----------------------------------------------------------------------------
// JPEG header segment extractor - segment parser
// Marker segment state machine; classifies one word and updates on step.
// ----------------------------------------------------------------------------
module jhse_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  jhse_pkg::item_t item,
  output jhse_pkg::res_t  res
);

  jhse_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] payload_left_r, payload_left_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic        is_sos_r, is_sos_nxt;
  logic [2:0]  final_code_r, final_code_nxt;

  logic [15:0] seg_len;
  logic [15:0] payload_dec;
  logic [2:0]  status;
  logic        keep;
  logic        last;

  assign seg_len     = {length_high_r, item.data_byte};
  assign payload_dec = payload_left_r - 16'd1;

  always_comb begin
    phase_nxt        = phase_r;
    payload_left_nxt = payload_left_r;
    length_high_nxt  = length_high_r;
    is_sos_nxt       = is_sos_r;
    final_code_nxt   = final_code_r;
    keep             = 1'b0;
    status           = jhse_pkg::ST_IN_HEADER;
    last             = 1'b0;

    if (phase_r == jhse_pkg::PH_FINISHED) begin
      if (final_code_r == jhse_pkg::ST_COMPLETE || final_code_r == jhse_pkg::ST_IN_HEADER)
        status = jhse_pkg::ST_PAST;
      else
        status = final_code_r;
    end else if (item.stream_end) begin
      if (phase_r == jhse_pkg::PH_SOI0 || phase_r == jhse_pkg::PH_SOI1)
        status = jhse_pkg::ST_NO_SOI;
      else
        status = jhse_pkg::ST_TRUNCATED;
    end else begin
      keep = 1'b1;
      case (phase_r)
        jhse_pkg::PH_SOI0: begin
          if (item.data_byte == jhse_pkg::MARK_PREFIX) phase_nxt = jhse_pkg::PH_SOI1;
          else status = jhse_pkg::ST_NO_SOI;
        end
        jhse_pkg::PH_SOI1: begin
          if (item.data_byte == jhse_pkg::MARK_SOI) phase_nxt = jhse_pkg::PH_PREFIX;
          else status = jhse_pkg::ST_NO_SOI;
        end
        jhse_pkg::PH_PREFIX: begin
          if (item.data_byte == jhse_pkg::MARK_PREFIX) phase_nxt = jhse_pkg::PH_CODE;
          else status = jhse_pkg::ST_BAD_PREFIX;
        end
        jhse_pkg::PH_CODE: begin
          if (item.data_byte == jhse_pkg::MARK_EOI) begin
            status = jhse_pkg::ST_EOI_EARLY;
          end else begin
            is_sos_nxt = (item.data_byte == jhse_pkg::MARK_SOS);
            phase_nxt  = jhse_pkg::PH_LENH;
          end
        end
        jhse_pkg::PH_LENH: begin
          length_high_nxt = item.data_byte;
          phase_nxt       = jhse_pkg::PH_LENL;
        end
        jhse_pkg::PH_LENL: begin
          if (seg_len < 16'd2) begin
            status = jhse_pkg::ST_BAD_LEN;
          end else if (seg_len == 16'd2) begin
            payload_left_nxt = 16'd0;
            if (is_sos_r) status = jhse_pkg::ST_COMPLETE;
            else phase_nxt = jhse_pkg::PH_PREFIX;
          end else begin
            payload_left_nxt = seg_len - 16'd2;
            phase_nxt        = jhse_pkg::PH_PAYLOAD;
          end
        end
        jhse_pkg::PH_PAYLOAD: begin
          payload_left_nxt = payload_dec;
          if (payload_dec == 16'd0) begin
            if (is_sos_r) status = jhse_pkg::ST_COMPLETE;
            else phase_nxt = jhse_pkg::PH_PREFIX;
          end
        end
        default: begin
          keep = 1'b0;
        end
      endcase
    end

    // any outcome ends the parse; only completion keeps its byte
    if (phase_r != jhse_pkg::PH_FINISHED && status != jhse_pkg::ST_IN_HEADER) begin
      if (status != jhse_pkg::ST_COMPLETE) keep = 1'b0;
      phase_nxt      = jhse_pkg::PH_FINISHED;
      final_code_nxt = status;
      last           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= jhse_pkg::PH_SOI0;
      payload_left_r <= 16'd0;
      length_high_r  <= 8'd0;
      is_sos_r       <= 1'b0;
      final_code_r   <= 3'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      payload_left_r <= payload_left_nxt;
      length_high_r  <= length_high_nxt;
      is_sos_r       <= is_sos_nxt;
      final_code_r   <= final_code_nxt;
    end
  end

  assign res.keep     = keep;
  assign res.byte_out = item.stream_end ? 8'd0 : item.data_byte;
  assign res.status   = status;
  assign res.last     = last;

endmodule

// ----- sv/jpeg_header_segment_extractor_core.sv -----
// ----------------------------------------------------------------------------
// JPEG header segment extractor - top level
// Input word register, segment parser, result word register.
// ----------------------------------------------------------------------------
//   channel  dir  word contents
//   in_ch    in   data_byte[7:0], stream_end
//   out_ch   out  keep, byte_out[7:0], status[2:0], last
//
// One word per cycle sustained while out_ch.ready holds; a word passes from
// the input register to the result register. The parser state updates
// on that move, so throughput is set by the parser's own update.
// Synchronous active-low reset returns the parser to the SOI check.
// A stalled result holds in its register; the input register still takes
// one more word, then in_ch.ready drops until out_ch.ready returns.
// ----------------------------------------------------------------------------
module jpeg_header_segment_extractor_core (
  input  logic       clk,
  input  logic       rst_n,
  jhse_in_if.sink    in_ch,
  jhse_out_if.source out_ch
);

  logic            in_vld_r, in_vld_nxt;
  jhse_pkg::item_t item_r;
  logic            out_vld_r, out_vld_nxt;
  jhse_pkg::res_t  res_r;
  jhse_pkg::res_t  res;
  logic            adv;
  logic            in_take;

  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) in_vld_nxt = 1'b1;
    else if (adv) in_vld_nxt = 1'b0;

    out_vld_nxt = out_vld_r;
    if (adv) out_vld_nxt = 1'b1;
    else if (out_ch.ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.data_byte  <= in_ch.data_byte;
      item_r.stream_end <= in_ch.stream_end;
    end
    if (adv) res_r <= res;
  end

  jhse_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item_r),
    .res   (res)
  );

  assign out_ch.valid    = out_vld_r;
  assign out_ch.keep     = res_r.keep;
  assign out_ch.byte_out = res_r.byte_out;
  assign out_ch.status   = res_r.status;
  assign out_ch.last     = res_r.last;

endmodule

// ----- dv/jhse_parse_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JPEG header segment extractor - result checker
// Watches both channels. Every accepted input word runs through a local
// segment-parse predictor and the expected result word is queued. Every
// accepted result word is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module jhse_parse_checker (
  input  logic  clk,
  input  logic  rst_n,
  jhse_in_if    in_ch,
  jhse_out_if   out_ch,
  output int    fail_count,
  output int    pending
);

  jhse_pkg::phase_t parse_ph;
  logic [15:0]      bytes_left;
  logic [7:0]       len_hi;
  logic             in_sos;
  logic [2:0]       outcome;
  jhse_pkg::res_t   expected_words [$];

  function automatic jhse_pkg::res_t next_parse_word(input logic [7:0] b, input logic e);
    jhse_pkg::res_t r;
    logic [15:0]    seg_len;
    r          = '0;
    r.byte_out = e ? 8'h00 : b;
    r.status   = jhse_pkg::ST_IN_HEADER;
    if (parse_ph == jhse_pkg::PH_FINISHED) begin
      r.status = (outcome == jhse_pkg::ST_COMPLETE || outcome == jhse_pkg::ST_IN_HEADER) ?
                 jhse_pkg::ST_PAST : outcome;
    end else if (e) begin
      r.status = (parse_ph == jhse_pkg::PH_SOI0 || parse_ph == jhse_pkg::PH_SOI1) ?
                 jhse_pkg::ST_NO_SOI : jhse_pkg::ST_TRUNCATED;
      r.last   = 1'b1;
      outcome  = r.status;
      parse_ph = jhse_pkg::PH_FINISHED;
    end else begin
      r.keep = 1'b1;
      case (parse_ph)
        jhse_pkg::PH_SOI0: begin
          if (b == jhse_pkg::MARK_PREFIX) parse_ph = jhse_pkg::PH_SOI1;
          else r.status = jhse_pkg::ST_NO_SOI;
        end
        jhse_pkg::PH_SOI1: begin
          if (b == jhse_pkg::MARK_SOI) parse_ph = jhse_pkg::PH_PREFIX;
          else r.status = jhse_pkg::ST_NO_SOI;
        end
        jhse_pkg::PH_PREFIX: begin
          if (b == jhse_pkg::MARK_PREFIX) parse_ph = jhse_pkg::PH_CODE;
          else r.status = jhse_pkg::ST_BAD_PREFIX;
        end
        jhse_pkg::PH_CODE: begin
          if (b == jhse_pkg::MARK_EOI) begin
            r.status = jhse_pkg::ST_EOI_EARLY;
          end else begin
            in_sos   = (b == jhse_pkg::MARK_SOS);
            parse_ph = jhse_pkg::PH_LENH;
          end
        end
        jhse_pkg::PH_LENH: begin
          len_hi   = b;
          parse_ph = jhse_pkg::PH_LENL;
        end
        jhse_pkg::PH_LENL: begin
          seg_len = {len_hi, b};
          if (seg_len < 16'd2) begin
            r.status = jhse_pkg::ST_BAD_LEN;
          end else if (seg_len == 16'd2) begin
            bytes_left = '0;
            if (in_sos) r.status = jhse_pkg::ST_COMPLETE;
            else parse_ph = jhse_pkg::PH_PREFIX;
          end else begin
            bytes_left = seg_len - 16'd2;
            parse_ph   = jhse_pkg::PH_PAYLOAD;
          end
        end
        default: begin
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == '0) begin
            if (in_sos) r.status = jhse_pkg::ST_COMPLETE;
            else parse_ph = jhse_pkg::PH_PREFIX;
          end
        end
      endcase
      if (r.status != jhse_pkg::ST_IN_HEADER) begin
        if (r.status != jhse_pkg::ST_COMPLETE) r.keep = 1'b0;
        r.last   = 1'b1;
        outcome  = r.status;
        parse_ph = jhse_pkg::PH_FINISHED;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    jhse_pkg::res_t want;
    int             errs;
    errs = 0;
    if (!rst_n) begin
      parse_ph   = jhse_pkg::PH_SOI0;
      bytes_left = '0;
      len_hi     = '0;
      in_sos     = 1'b0;
      outcome    = jhse_pkg::ST_IN_HEADER;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_words = {expected_words,
                          next_parse_word(in_ch.data_byte, in_ch.stream_end)};
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing outstanding: byte_out %0h status %0d",
                 out_ch.byte_out, out_ch.status);
          errs++;
        end else begin
          want = expected_words.pop_front();
          if (out_ch.keep !== want.keep) begin
            $error("keep mismatch: expected %0d, got %0d", want.keep, out_ch.keep);
            errs++;
          end
          if (out_ch.byte_out !== want.byte_out) begin
            $error("byte_out mismatch: expected %0h, got %0h", want.byte_out, out_ch.byte_out);
            errs++;
          end
          if (out_ch.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_ch.status);
            errs++;
          end
          if (out_ch.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, out_ch.last);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= expected_words.size();
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JPEG header segment extractor - testbench top
// Feeds one JPEG-like byte stream per run: a bad or cut-short SOI, or SOI,
// a short fixed run of segments, random segments with random payload, then
// a seed-chosen ending (header complete or one of the parse errors); then
// trailing words. Sender idling and receiver stalls change across phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         HEADER_WORDS   = 620;
  localparam int         TOTAL_WORDS    = 950;
  localparam logic [7:0] CODE_APP0      = 8'hE0;
  localparam logic [7:0] CODE_ZERO      = 8'h00;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   n_sent;
  int   in_idle_pct;
  int   out_stall_pct;
  int   idle_cycles;

  jhse_in_if  in_ch ();
  jhse_out_if out_ch ();

  jpeg_header_segment_extractor_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  jhse_parse_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [7:0] b, input logic e);
    case ((n_sent / 64) % 5)
      1:       begin in_idle_pct = 78; out_stall_pct = 0;  end
      2:       begin in_idle_pct = 0;  out_stall_pct = 78; end
      3:       begin in_idle_pct = 38; out_stall_pct = 38; end
      default: begin in_idle_pct = 0;  out_stall_pct = 0;  end
    endcase
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.stream_end <= e;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_sent++;
  endtask

  // FF, code, length, random payload; only the first cut words when cut >= 0
  task automatic send_segment(input logic [7:0] code, input int seg_len, input int cut);
    logic [7:0] seg [$];
    int         n;
    seg = '{jhse_pkg::MARK_PREFIX, code, seg_len[15:8], seg_len[7:0]};
    for (int i = 0; i < seg_len - 2; i++) seg = {seg, 8'($urandom)};
    n = (cut < 0 || cut > seg.size()) ? seg.size() : cut;
    for (int i = 0; i < n; i++) send_word(seg[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) return jhse_pkg::MARK_PREFIX;
    do c = 8'($urandom); while (c == jhse_pkg::MARK_EOI || c == jhse_pkg::MARK_SOS);
    return c;
  endfunction

  initial begin
    logic [7:0] intro [];
    int         scenario;
    int         big_left;
    int         seg_len;
    logic [7:0] b;

    intro = '{jhse_pkg::MARK_PREFIX, jhse_pkg::MARK_SOI,
              jhse_pkg::MARK_PREFIX, CODE_APP0, 8'h00, 8'h02,
              jhse_pkg::MARK_PREFIX, jhse_pkg::MARK_PREFIX, 8'h00, 8'h04, 8'h00, 8'hFF,
              jhse_pkg::MARK_PREFIX, CODE_ZERO, 8'h00, 8'h03, 8'h80};
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.stream_end = 1'b0;
    n_sent           = 0;
    in_idle_pct      = 0;
    out_stall_pct    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    scenario = $urandom_range(0, 15);
    big_left = $urandom_range(1, 2);

    if (scenario == 0) begin
      // bad SOI byte, first or second
      if ($urandom_range(0, 1)) begin
        send_word(8'($urandom_range(0, 254)), 1'b0);
      end else begin
        send_word(jhse_pkg::MARK_PREFIX, 1'b0);
        do b = 8'($urandom); while (b == jhse_pkg::MARK_SOI);
        send_word(b, 1'b0);
      end
    end else if (scenario == 1) begin
      // end of file before SOI is complete
      if ($urandom_range(0, 1)) send_word(jhse_pkg::MARK_PREFIX, 1'b0);
      send_word(8'($urandom), 1'b1);
    end else begin
      foreach (intro[i]) send_word(intro[i], 1'b0);
      while (n_sent < HEADER_WORDS) begin
        if (big_left > 0 && n_sent + 256 < HEADER_WORDS && $urandom_range(0, 9) == 0) begin
          seg_len = $urandom_range(256, HEADER_WORDS - n_sent);
          big_left--;
        end else if ($urandom_range(0, 5) == 0) begin
          seg_len = 2;
        end else begin
          seg_len = $urandom_range(3, 40);
        end
        send_segment(pick_code(), seg_len, -1);
      end
      case (scenario)
        2, 3: begin
          send_word(8'($urandom_range(0, 254)), 1'b0);
        end
        4, 5: begin
          send_word(jhse_pkg::MARK_PREFIX, 1'b0);
          send_word(jhse_pkg::MARK_EOI, 1'b0);
        end
        6, 7: begin
          send_segment($urandom_range(0, 1) ? jhse_pkg::MARK_SOS : pick_code(),
                       $urandom_range(0, 1), -1);
        end
        8, 9: begin
          seg_len = $urandom_range(2, 12);
          send_segment($urandom_range(0, 1) ? jhse_pkg::MARK_SOS : pick_code(), seg_len,
                       $urandom_range(0, seg_len + 1));
          send_word(8'($urandom), 1'b1);
        end
        default: begin
          send_segment(jhse_pkg::MARK_SOS,
                       $urandom_range(0, 3) == 0 ? 2 : $urandom_range(3, 20), -1);
        end
      endcase
    end

    // trailing words after the parse has ended
    while (n_sent < TOTAL_WORDS)
      send_word(8'($urandom), $urandom_range(0, 15) == 0);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
